// ----- hdl/caldc_pkg.sv -----
// ----------------------------------------------------------------------------
// caldc_pkg
// Shared types, constants and small calendar helper functions for the
// Gregorian calendar date counter.
// ----------------------------------------------------------------------------
package caldc_pkg;

   // Field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int CENT_W  = 6;   // year / 100, at most 40
   localparam int YREM_W  = 7;   // year % 100
   localparam int WDAY_W  = 3;
   localparam int WSUM_W  = 8;   // weekday sum, at most 166

   typedef logic [1:0]         action_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [CENT_W-1:0]  cent_type;
   typedef logic [YREM_W-1:0]  yrem_type;
   typedef logic [WDAY_W-1:0]  wday_type;
   typedef logic [WSUM_W-1:0]  wsum_type;

   // Action codes (code 3 behaves as read)
   localparam action_type ACT_LOAD    = 2'd0;
   localparam action_type ACT_ADVANCE = 2'd1;
   localparam action_type ACT_READ    = 2'd2;

   // Valid year range
   localparam year_type YEAR_MIN = 12'd1980;
   localparam year_type YEAR_MAX = 12'd2080;

   // Months
   localparam month_type MONTH_JAN = 4'd1;
   localparam month_type MONTH_FEB = 4'd2;
   localparam month_type MONTH_APR = 4'd4;
   localparam month_type MONTH_JUN = 4'd6;
   localparam month_type MONTH_SEP = 4'd9;
   localparam month_type MONTH_NOV = 4'd11;
   localparam month_type MONTH_DEC = 4'd12;

   // Month lengths
   localparam day_type DAY_FIRST         = 5'd1;
   localparam day_type DAY_LAST_LONG     = 5'd31;
   localparam day_type DAY_LAST_SHORT    = 5'd30;
   localparam day_type DAY_LAST_FEB_LEAP = 5'd29;
   localparam day_type DAY_LAST_FEB      = 5'd28;

   // Year split into century and year-of-century
   localparam yrem_type   YREM_LAST   = 7'd99;
   localparam year_type   CENTURY_LEN = 12'd100;
   localparam logic [15:0] RECIP_100  = 16'd41944;  // 2^22 / 100, rounded up
   localparam int         RECIP_100_SH = 22;

   // Mod 7 by reciprocal
   localparam wsum_type   DAYS_PER_WEEK = 8'd7;
   localparam logic [7:0] RECIP_7       = 8'd147;   // 2^10 / 7, rounded up
   localparam int         RECIP_7_SH    = 10;

   // 30-day months
   function automatic logic is_short_month(input month_type m);
      return (m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) || (m == MONTH_NOV);
   endfunction

   // Leap rule from year / 100 and year % 100
   function automatic logic leap_of(input yrem_type rem, input cent_type cent);
      logic leap;
      if (rem == '0) begin
         leap = (cent[1:0] == 2'b00);
      end else begin
         leap = (rem[1:0] == 2'b00);
      end
      return leap;
   endfunction

   // Last day of a month
   function automatic day_type month_length(input month_type m, input logic leap);
      day_type len;
      if (m == MONTH_FEB) begin
         len = leap ? DAY_LAST_FEB_LEAP : DAY_LAST_FEB;
      end else if (is_short_month(m)) begin
         len = DAY_LAST_SHORT;
      end else begin
         len = DAY_LAST_LONG;
      end
      return len;
   endfunction

   // Table-method month value, with the leap-year January/February shift
   function automatic wday_type month_value(input month_type m, input logic leap);
      wday_type mv;
      case (m)
         4'd0:    mv = 3'd0;
         4'd1:    mv = leap ? 3'd6 : 3'd0;
         4'd2:    mv = leap ? 3'd2 : 3'd3;
         4'd3:    mv = 3'd3;
         4'd4:    mv = 3'd6;
         4'd5:    mv = 3'd1;
         4'd6:    mv = 3'd4;
         4'd7:    mv = 3'd6;
         4'd8:    mv = 3'd2;
         4'd9:    mv = 3'd5;
         4'd10:   mv = 3'd0;
         4'd11:   mv = 3'd3;
         default: mv = 3'd5;
      endcase
      return mv;
   endfunction

   // Table-method century value: (3 - century % 4) * 2
   function automatic wday_type century_value(input cent_type cent);
      wday_type cv;
      case (cent[1:0])
         2'd0:    cv = 3'd6;
         2'd1:    cv = 3'd4;
         2'd2:    cv = 3'd2;
         default: cv = 3'd0;
      endcase
      return cv;
   endfunction

   // s % 7 for s up to 166, via multiply by reciprocal
   function automatic wday_type mod7(input wsum_type s);
      logic [15:0] prod;
      logic [4:0]  q;
      wsum_type    r;
      prod = {8'b0, s} * {8'b0, RECIP_7};
      q    = prod[RECIP_7_SH+4:RECIP_7_SH];
      r    = s - ({3'b000, q} * DAYS_PER_WEEK);
      return r[WDAY_W-1:0];
   endfunction

endpackage

// ----- hdl/caldc_req_if.sv -----
// ----------------------------------------------------------------------------
// caldc_req_if
// Request channel of the calendar date counter: valid/ready plus one word.
// ----------------------------------------------------------------------------
interface caldc_req_if import caldc_pkg::*; ();

   logic       valid;
   logic       ready;
   action_type action;
   day_type    load_day;
   month_type  load_month;
   year_type   load_year;

   modport source (output valid, action, load_day, load_month, load_year, input ready);
   modport sink   (input valid, action, load_day, load_month, load_year, output ready);

endinterface

// ----- hdl/caldc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// caldc_rsp_if
// Response channel of the calendar date counter: valid/ready plus one word.
// ----------------------------------------------------------------------------
interface caldc_rsp_if import caldc_pkg::*; ();

   logic      valid;
   logic      ready;
   day_type   day_out;
   month_type month_out;
   year_type  year_out;
   logic      date_valid;
   logic      leap_year;
   wday_type  weekday;

   modport source (output valid, day_out, month_out, year_out, date_valid, leap_year,
                   weekday, input ready);
   modport sink   (input valid, day_out, month_out, year_out, date_valid, leap_year,
                   weekday, output ready);

endinterface

// ----- hdl/calendar_date_counter_core.sv -----
// ----------------------------------------------------------------------------
// calendar_date_counter_core
// Gregorian date register with load / advance-one-day / read requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per request: action (load, advance, read) and
//   the date to load. rsp_chan returns one word per request: the stored date
//   after the request, a validity flag (1980..2080, legal month and day), a
//   leap-year flag and the day of week (0 = Sunday, 0 when invalid).
//   On request accept the date registers update; the response register then
//   captures the word computed from them once it is free. Throughput is one
//   word per cycle while rsp ready stays high, set by the single date
//   register update; the year is kept also as century and year-of-century
//   so the leap and weekday logic stays short.
//   Reset (synchronous, active high) clears the date to the null date
//   0-0-0 and empties both stages. When the receiver holds rsp ready low,
//   the response register and one word in the update stage stay put and
//   req ready drops until the response is taken.
// ----------------------------------------------------------------------------
module calendar_date_counter_core import caldc_pkg::*; (
   input logic          clock,
   input logic          reset,
   caldc_req_if.sink    req_chan,
   caldc_rsp_if.source  rsp_chan
);

   // Date state, with the year also split as year / 100 and year % 100
   day_type   day_ff,   day_in;
   month_type month_ff, month_in;
   year_type  year_ff,  year_in;
   cent_type  cent_ff,  cent_in;
   yrem_type  yrem_ff,  yrem_in;

   // Pipeline control
   logic s1_valid_ff,  s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_take;

   // Response word registers
   day_type   day_out_ff;
   month_type month_out_ff;
   year_type  year_out_ff;
   logic      date_valid_ff;
   logic      leap_year_ff;
   wday_type  weekday_ff;

   // Flags of the stored date
   logic     leap_cur;
   logic     valid_cur;
   wday_type weekday_cur;
   wsum_type wsum;

   // Load path: split the requested year
   logic [YEAR_W+15:0] ld_prod;
   cent_type           ld_cent;
   year_type           ld_rem_full;

   // Handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Leap and validity of the stored date
   always_comb begin
      leap_cur  = leap_of(yrem_ff, cent_ff);
      valid_cur = (year_ff >= YEAR_MIN) && (year_ff <= YEAR_MAX) &&
                  (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                  (day_ff != '0) && (day_ff <= month_length(month_ff, leap_cur));
   end

   // Day of week, table method
   always_comb begin
      wsum = wsum_type'(day_ff) + wsum_type'(month_value(month_ff, leap_cur)) +
             wsum_type'(century_value(cent_ff)) + wsum_type'(yrem_ff) +
             wsum_type'(yrem_ff >> 2);
      weekday_cur = valid_cur ? mod7(wsum) : '0;
   end

   // year / 100 by reciprocal, remainder by subtract
   always_comb begin
      ld_prod     = {16'b0, req_chan.load_year} * {{YEAR_W{1'b0}}, RECIP_100};
      ld_cent     = ld_prod[RECIP_100_SH+CENT_W-1:RECIP_100_SH];
      ld_rem_full = req_chan.load_year - ({{(YEAR_W-CENT_W){1'b0}}, ld_cent} * CENTURY_LEN);
   end

   // Next date
   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      cent_in  = cent_ff;
      yrem_in  = yrem_ff;
      if (req_take) begin
         case (req_chan.action)
            ACT_LOAD: begin
               day_in   = req_chan.load_day;
               month_in = req_chan.load_month;
               year_in  = req_chan.load_year;
               cent_in  = ld_cent;
               yrem_in  = ld_rem_full[YREM_W-1:0];
            end
            ACT_ADVANCE: begin
               // only a legal date moves
               if (valid_cur) begin
                  if (day_ff == month_length(month_ff, leap_cur)) begin
                     day_in = DAY_FIRST;
                     if (month_ff == MONTH_DEC) begin
                        month_in = MONTH_JAN;
                        year_in  = year_ff + 1'b1;
                        if (yrem_ff == YREM_LAST) begin
                           yrem_in = '0;
                           cent_in = cent_ff + 1'b1;
                        end else begin
                           yrem_in = yrem_ff + 1'b1;
                        end
                     end else begin
                        month_in = month_ff + 1'b1;
                     end
                  end else begin
                     day_in = day_ff + 1'b1;
                  end
               end
            end
            default: begin
               // read only
            end
         endcase
      end
   end

   // Stage valid bits
   always_comb begin
      s1_valid_in  = req_chan.ready ? req_chan.valid : s1_valid_ff;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   // Control and date registers
   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff       <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         cent_ff      <= '0;
         yrem_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         cent_ff      <= cent_in;
         yrem_ff      <= yrem_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response word capture
   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         day_out_ff    <= day_ff;
         month_out_ff  <= month_ff;
         year_out_ff   <= year_ff;
         date_valid_ff <= valid_cur;
         leap_year_ff  <= leap_cur;
         weekday_ff    <= weekday_cur;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.day_out    = day_out_ff;
   assign rsp_chan.month_out  = month_out_ff;
   assign rsp_chan.year_out   = year_out_ff;
   assign rsp_chan.date_valid = date_valid_ff;
   assign rsp_chan.leap_year  = leap_year_ff;
   assign rsp_chan.weekday    = weekday_ff;

`ifndef SYNTHESIS
   // century split always matches the full year
   a_year_split: assert property (@(posedge clock) disable iff (reset)
      year_ff == (({{(YEAR_W-CENT_W){1'b0}}, cent_ff} * CENTURY_LEN) +
                  {{(YEAR_W-YREM_W){1'b0}}, yrem_ff}))
      else $error("year and century split disagree");

   a_yrem_range: assert property (@(posedge clock) disable iff (reset)
      yrem_ff <= YREM_LAST)
      else $error("year of century out of range");

   // a word held in the update stage freezes the date
   a_hold_date: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=>
         ($stable(day_ff) && $stable(month_ff) && $stable(year_ff)))
      else $error("date changed while update stage stalled");

   // every accepted request reaches the update stage
   a_take_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request lost");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load / advance / read words into the calendar date counter and
// checks every response word field by field against a date predictor kept
// in step with each accepted request. A directed table comes first, then
// random date runs across month, February and year ends, with random
// stalls on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module testbench import caldc_pkg::*; ();

   localparam action_type ACT_SPARE  = 2'd3;   // unused code, reads only
   localparam int RANDOM_WORDS      = 1200;
   localparam int STALL_LIMIT       = 2000;   // cycles without any transfer
   localparam int QUIET_FIRST       = 600;    // no idling on either side
   localparam int QUIET_LAST        = 800;
   localparam int HOLD_AT           = 200;    // response hold-off trigger
   localparam int HOLD_CYCLES       = 300;

   typedef struct packed {
      day_type   day;
      month_type month;
      year_type  year;
      logic      valid;
      logic      leap;
      wday_type  wday;
   } date_word_type;

   typedef struct packed {
      action_type    action;
      day_type       day;
      month_type     month;
      year_type      year;
      logic          typed;
      date_word_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   caldc_req_if req_chan ();
   caldc_rsp_if rsp_chan ();

   calendar_date_counter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted date registers
   day_type    cur_day;
   month_type  cur_month;
   year_type   cur_year;

   date_word_type expected_dates[$];
   stim_row_type  directed_rows[$];
   int            words_sent;
   int            words_checked;
   int            mismatches;
   int            hold_left;
   bit            hold_done;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Date predictor
   // ---------------------------------------------------------------------
   function automatic bit leap_rule(input year_type y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic day_type last_day(input month_type m, input year_type y);
      if (m == MONTH_FEB) begin
         return leap_rule(y) ? DAY_LAST_FEB_LEAP : DAY_LAST_FEB;
      end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         return DAY_LAST_SHORT;
      end
      return DAY_LAST_LONG;
   endfunction

   function automatic bit date_good(input day_type d, input month_type m, input year_type y);
      if (y < YEAR_MIN || y > YEAR_MAX) return 1'b0;
      if (m < MONTH_JAN || m > MONTH_DEC) return 1'b0;
      return (d >= DAY_FIRST) && (d <= last_day(m, y));
   endfunction

   // Table method: day + month value + century value + year value, mod 7
   function automatic wday_type day_of_week(input day_type d, input month_type m,
                                            input year_type y);
      int mv;
      int yy;
      int cv;
      case (m)
         4'd2, 4'd3, 4'd11: mv = 3;
         4'd4, 4'd7:        mv = 6;
         4'd5:              mv = 1;
         4'd6:              mv = 4;
         4'd8:              mv = 2;
         4'd9:              mv = 5;
         4'd0, 4'd1, 4'd10: mv = 0;
         default:           mv = 5;
      endcase
      // leap years shift January and February back one day
      if (leap_rule(y) && m == MONTH_JAN) mv = 6;
      if (leap_rule(y) && m == MONTH_FEB) mv = 2;
      yy = int'(y) % 100;
      cv = (3 - (int'(y) / 100) % 4) * 2;
      return wday_type'((int'(d) + mv + cv + yy + yy / 4) % 7);
   endfunction

   function automatic void add_row(input action_type a, input day_type d, input month_type m,
                                   input year_type y, input logic typed, input day_type ed,
                                   input month_type em, input year_type ey, input logic ev,
                                   input logic el, input wday_type ew);
      stim_row_type row;
      row.action     = a;
      row.day        = d;
      row.month      = m;
      row.year       = y;
      row.typed      = typed;
      row.want.day   = ed;
      row.want.month = em;
      row.want.year  = ey;
      row.want.valid = ev;
      row.want.leap  = el;
      row.want.wday  = ew;
      directed_rows.push_back(row);
   endfunction

   // Offer one request word, wait for it to be taken, then predict its response
   task automatic send_date_word(input action_type a, input day_type d, input month_type m,
                                 input year_type y, input logic typed,
                                 input date_word_type want);
      date_word_type next;
      bit            quiet;
      req_chan.valid      <= 1'b1;
      req_chan.action     <= a;
      req_chan.load_day   <= d;
      req_chan.load_month <= m;
      req_chan.load_year  <= y;
      do @(posedge clock); while (!req_chan.ready);

      case (a)
         ACT_LOAD: begin
            cur_day   = d;
            cur_month = m;
            cur_year  = y;
         end
         ACT_ADVANCE: begin
            if (date_good(cur_day, cur_month, cur_year)) begin
               if (cur_day < last_day(cur_month, cur_year)) begin
                  cur_day = cur_day + 1'b1;
               end else begin
                  cur_day   = DAY_FIRST;
                  cur_month = cur_month + 1'b1;
               end
               if (cur_month > MONTH_DEC) begin
                  cur_month = MONTH_JAN;
                  cur_year  = cur_year + 1'b1;
               end
            end
         end
         default: ;
      endcase
      next.day   = cur_day;
      next.month = cur_month;
      next.year  = cur_year;
      next.valid = date_good(cur_day, cur_month, cur_year);
      next.leap  = leap_rule(cur_year);
      next.wday  = next.valid ? day_of_week(cur_day, cur_month, cur_year) : '0;
      expected_dates.push_back(typed ? want : next);
      words_sent++;

      // random gaps between request words, none in the quiet stretch
      quiet = (words_sent >= QUIET_FIRST) && (words_sent < QUIET_LAST);
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------------
   // Request side: directed table, then random date runs
   // ---------------------------------------------------------------------
   initial begin : request_side
      date_word_type none;
      stim_row_type  row;
      int            total;
      int            pick;
      int            run_len;
      day_type       d;
      month_type     m;
      year_type      y;
      day_type       len;

      none                = '0;
      words_sent          = 0;
      cur_day             = '0;
      cur_month           = '0;
      cur_year            = '0;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_READ;
      req_chan.load_day   <= '0;
      req_chan.load_month <= '0;
      req_chan.load_year  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // null date after reset reads as invalid, leap (year 0), weekday 0
      add_row(ACT_READ,    0,  0,    0, 1,  0,  0,    0, 0, 1, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 1,  0,  0,    0, 0, 1, 0);
      add_row(ACT_SPARE,   0,  0,    0, 1,  0,  0,    0, 0, 1, 0);
      add_row(ACT_LOAD,   31, 15, 4095, 1, 31, 15, 4095, 0, 0, 0);
      add_row(ACT_LOAD,    0,  0,    0, 1,  0,  0,    0, 0, 1, 0);
      add_row(ACT_LOAD,    1,  1, 1980, 0,  0,  0,    0, 0, 0, 0);
      // February end in a leap year, a common year and a 400-year
      add_row(ACT_LOAD,   28,  2, 1980, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_LOAD,   28,  2, 2079, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_LOAD,   28,  2, 2000, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 0,  0,  0,    0, 0, 0, 0);
      // century year out of range: not leap, advance leaves it alone
      add_row(ACT_LOAD,   29,  2, 2100, 1, 29,  2, 2100, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 1, 29,  2, 2100, 0, 0, 0);
      // 30- and 31-day month ends
      add_row(ACT_LOAD,   30,  4, 2020, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_LOAD,   31,  1, 1980, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 0,  0,  0,    0, 0, 0, 0);
      // last valid day rolls into 2081, which is invalid and then sticks
      add_row(ACT_LOAD,   31, 12, 2080, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 1,  1,  1, 2081, 0, 0, 0);
      add_row(ACT_ADVANCE, 0,  0,    0, 1,  1,  1, 2081, 0, 0, 0);
      // day beyond the month length, day zero
      add_row(ACT_LOAD,   31,  4, 2020, 0,  0,  0,    0, 0, 0, 0);
      add_row(ACT_LOAD,    0,  1, 2000, 1,  0,  1, 2000, 0, 1, 0);
      add_row(ACT_LOAD,   29,  2, 2021, 0,  0,  0,    0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_date_word(row.action, row.day, row.month, row.year, row.typed, row.want);
      end

      // random part: mostly valid dates followed by runs of advances
      total = words_sent + RANDOM_WORDS;
      while (words_sent < total) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 19) == 0) begin
               y = YEAR_MAX;
               m = MONTH_DEC;
            end else begin
               y = year_type'($urandom_range(YEAR_MIN, YEAR_MAX));
               m = month_type'($urandom_range(MONTH_JAN, MONTH_DEC));
            end
            len = last_day(m, y);
            if ($urandom_range(0, 1) == 0) begin
               d = day_type'($urandom_range(len - 2, len));
            end else begin
               d = day_type'($urandom_range(DAY_FIRST, len));
            end
            send_date_word(ACT_LOAD, d, m, y, 1'b0, none);
            run_len = $urandom_range(1, 40);
            repeat (run_len) begin
               pick = $urandom_range(0, 19);
               send_date_word(pick == 0 ? ACT_READ : (pick == 1 ? ACT_SPARE : ACT_ADVANCE),
                              day_type'($urandom), month_type'($urandom),
                              year_type'($urandom), 1'b0, none);
            end
         end else if (pick < 85) begin
            // any load pattern, then a few random actions on it
            send_date_word(ACT_LOAD, day_type'($urandom), month_type'($urandom),
                           year_type'($urandom), 1'b0, none);
            repeat ($urandom_range(0, 3)) begin
               send_date_word(action_type'($urandom_range(0, 3)), day_type'($urandom),
                              month_type'($urandom), year_type'($urandom), 1'b0, none);
            end
         end else begin
            send_date_word(action_type'($urandom_range(0, 3)), day_type'($urandom),
                           month_type'($urandom), year_type'($urandom), 1'b0, none);
         end
      end
      req_chan.valid <= 1'b0;

      // drain, then allow time for any stray response word
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_dates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random ready, one long hold-off, field checks
   // ---------------------------------------------------------------------
   initial begin : response_side
      date_word_type want;
      words_checked = 0;
      mismatches    = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_dates.size() == 0) begin
               $error("response word with no request pending");
               mismatches++;
            end else begin
               want = expected_dates.pop_front();
               if (rsp_chan.day_out !== want.day) begin
                  $error("day_out: expected %0d, got %0d", want.day, rsp_chan.day_out);
                  mismatches++;
               end
               if (rsp_chan.month_out !== want.month) begin
                  $error("month_out: expected %0d, got %0d", want.month, rsp_chan.month_out);
                  mismatches++;
               end
               if (rsp_chan.year_out !== want.year) begin
                  $error("year_out: expected %0d, got %0d", want.year, rsp_chan.year_out);
                  mismatches++;
               end
               if (rsp_chan.date_valid !== want.valid) begin
                  $error("date_valid: expected %0b, got %0b", want.valid, rsp_chan.date_valid);
                  mismatches++;
               end
               if (rsp_chan.leap_year !== want.leap) begin
                  $error("leap_year: expected %0b, got %0b", want.leap, rsp_chan.leap_year);
                  mismatches++;
               end
               if (rsp_chan.weekday !== want.wday) begin
                  $error("weekday: expected %0d, got %0d", want.wday, rsp_chan.weekday);
                  mismatches++;
               end
            end
            words_checked++;
         end

         // one long hold-off so the core backs up and drops req ready
         if (!hold_done && words_checked == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (words_checked >= QUIET_FIRST && words_checked < QUIET_LAST) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without a transfer on either channel
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
